FILE: hdl/twhbl_pkg.sv
// ----------------------------------------------------------------------------
// twhbl_pkg
// Shared types and constants of the two-wire handshake byte link.
// ----------------------------------------------------------------------------
package twhbl_pkg;

  // request opcodes
  localparam logic [1:0] OP_TICK = 2'd0;
  localparam logic [1:0] OP_SEND = 2'd1;
  localparam logic [1:0] OP_RECV = 2'd2;

  // completion status codes
  localparam logic [1:0] ST_OK          = 2'd0;
  localparam logic [1:0] ST_TX_TIMEOUT  = 2'd1;
  localparam logic [1:0] ST_RX_START_TO = 2'd2;
  localparam logic [1:0] ST_RX_ACK_TO   = 2'd3;

  // configuration register indexes
  localparam logic CFG_HANDSHAKE_TIMEOUT = 1'b0;
  localparam logic CFG_BIT_START_TIMEOUT = 1'b1;

  localparam int unsigned TIMER_W = 24;
  localparam logic [TIMER_W-1:0] TIMEOUT_RESET = 24'd1000000;

  // receive shift input position and drive masks
  localparam logic [7:0] RX_MSB   = 8'h80;
  localparam logic [1:0] DRV_TIP  = 2'b01;
  localparam logic [1:0] DRV_RING = 2'b10;
  localparam logic [1:0] DRV_NONE = 2'b00;

  typedef enum logic [2:0] {
    PH_IDLE     = 3'd0,
    PH_TX_HIGH  = 3'd1,
    PH_TX_ACK   = 3'd2,
    PH_TX_REL   = 3'd3,
    PH_RX_START = 3'd4,
    PH_RX_REL   = 3'd5
  } phase_t;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] tx_byte;
    logic       tip_high;
    logic       ring_high;
  } in_t;

  typedef struct packed {
    logic       tip_pull_low;
    logic       ring_pull_low;
    logic       busy_res;
    logic       done_res;
    logic [1:0] status;
    logic [7:0] rx_byte;
  } out_t;

  typedef struct packed {
    logic [TIMER_W-1:0] handshake_timeout;
    logic [TIMER_W-1:0] bit_start_timeout;
  } cfg_t;

  typedef struct packed {
    phase_t             phase;
    logic               receiving;
    logic [3:0]         bits_done;
    logic [7:0]         shift_reg;
    logic [TIMER_W-1:0] wait_timer;
    logic               current_bit;
    logic [1:0]         drive_lines;
  } link_state_t;

endpackage

FILE: hdl/twhbl_cfg.sv
// ----------------------------------------------------------------------------
// twhbl_cfg
// Timeout register file written through the plain configuration port.
// ----------------------------------------------------------------------------
module twhbl_cfg
  import twhbl_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [TIMER_W-1:0] cfg_data,
  output cfg_t               cfg
);

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.handshake_timeout <= TIMEOUT_RESET;
      cfg_r.bit_start_timeout <= TIMEOUT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_HANDSHAKE_TIMEOUT: cfg_r.handshake_timeout <= cfg_data;
        CFG_BIT_START_TIMEOUT: cfg_r.bit_start_timeout <= cfg_data;
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

FILE: hdl/twhbl_step.sv
// ----------------------------------------------------------------------------
// twhbl_step
// One tick of the handshake state machine: next state and result item.
// ----------------------------------------------------------------------------
module twhbl_step
  import twhbl_pkg::*;
#(
  parameter int unsigned BITS_PER_CHAR = 8
) (
  input  link_state_t st_cur,
  input  in_t         item,
  input  cfg_t        cfg,
  output link_state_t st_nxt,
  output out_t        res
);

  localparam logic [4:0] LAST_COUNT = 5'(BITS_PER_CHAR);

  always_comb begin
    link_state_t s;
    logic        bit_end;
    logic        done;
    logic [1:0]  err;
    logic [7:0]  rx;
    s       = st_cur;
    bit_end = 1'b0;
    done    = 1'b0;
    err     = ST_OK;
    rx      = 8'd0;

    // starts are only taken while idle
    if (s.phase == PH_IDLE && (item.op == OP_SEND || item.op == OP_RECV)) begin
      s.receiving   = (item.op == OP_RECV);
      s.phase       = (item.op == OP_RECV) ? PH_RX_START : PH_TX_HIGH;
      s.shift_reg   = (item.op == OP_RECV) ? 8'd0 : item.tx_byte;
      s.bits_done   = 4'd0;
      s.wait_timer  = '0;
      s.current_bit = 1'b0;
      s.drive_lines = DRV_NONE;
    end

    unique case (s.phase)
      PH_IDLE: ;
      PH_TX_HIGH: begin
        if (item.tip_high && item.ring_high) begin
          s.current_bit = s.shift_reg[0];
          s.drive_lines = s.shift_reg[0] ? DRV_RING : DRV_TIP;
          s.wait_timer  = '0;
          s.phase       = PH_TX_ACK;
        end else if (s.wait_timer >= cfg.handshake_timeout) begin
          err = ST_TX_TIMEOUT;
        end else begin
          s.wait_timer = s.wait_timer + 24'd1;
        end
      end
      PH_TX_ACK: begin
        if (!(s.current_bit ? item.tip_high : item.ring_high)) begin
          s.drive_lines = DRV_NONE;
          s.wait_timer  = '0;
          s.phase       = PH_TX_REL;
        end else if (s.wait_timer >= cfg.handshake_timeout) begin
          err = ST_TX_TIMEOUT;
        end else begin
          s.wait_timer = s.wait_timer + 24'd1;
        end
      end
      PH_TX_REL: begin
        if (s.current_bit ? item.tip_high : item.ring_high) begin
          s.shift_reg = s.shift_reg >> 1;
          bit_end     = 1'b1;
        end else if (s.wait_timer >= cfg.handshake_timeout) begin
          err = ST_TX_TIMEOUT;
        end else begin
          s.wait_timer = s.wait_timer + 24'd1;
        end
      end
      PH_RX_START: begin
        if (!(item.tip_high && item.ring_high)) begin
          // ring low with tip high is a one, anything else a zero
          s.current_bit = item.tip_high && !item.ring_high;
          s.shift_reg   = (s.shift_reg >> 1) | (s.current_bit ? RX_MSB : 8'd0);
          s.drive_lines = s.current_bit ? DRV_TIP : DRV_RING;
          s.wait_timer  = '0;
          s.phase       = PH_RX_REL;
        end else if (s.wait_timer >= cfg.bit_start_timeout) begin
          err = ST_RX_START_TO;
        end else begin
          s.wait_timer = s.wait_timer + 24'd1;
        end
      end
      PH_RX_REL: begin
        if (s.current_bit ? item.ring_high : item.tip_high) begin
          s.drive_lines = DRV_NONE;
          bit_end       = 1'b1;
        end else if (s.wait_timer >= cfg.handshake_timeout) begin
          err = ST_RX_ACK_TO;
        end else begin
          s.wait_timer = s.wait_timer + 24'd1;
        end
      end
      default: s.phase = PH_IDLE;
    endcase

    if (bit_end) begin
      s.wait_timer = '0;
      if (({1'b0, s.bits_done} + 5'd1) >= LAST_COUNT) begin
        done        = 1'b1;
        rx          = s.receiving ? s.shift_reg : 8'd0;
        s.phase     = PH_IDLE;
        s.bits_done = 4'd0;
      end else begin
        s.bits_done = s.bits_done + 4'd1;
        s.phase     = s.receiving ? PH_RX_START : PH_TX_HIGH;
      end
    end

    if (err != ST_OK) begin
      s.drive_lines = DRV_NONE;
      s.phase       = PH_IDLE;
      s.wait_timer  = '0;
      s.bits_done   = 4'd0;
      done          = 1'b1;
    end

    st_nxt            = s;
    res.tip_pull_low  = s.drive_lines[0];
    res.ring_pull_low = s.drive_lines[1];
    res.busy_res      = (s.phase != PH_IDLE);
    res.done_res      = done;
    res.status        = err;
    res.rx_byte       = rx;
  end

endmodule

FILE: hdl/two_wire_handshake_byte_link.sv
// ----------------------------------------------------------------------------
// two_wire_handshake_byte_link
// Open-drain tip/ring handshake link moving one byte, least significant bit
// first, advanced by one timer tick per request.
// ----------------------------------------------------------------------------
// Every input request is one timer tick carrying the sampled tip and ring
// levels; it may also start a send (op 1) or a receive (op 2), which is
// ignored while a transfer is running. Exactly one result request comes back
// for every input request, in the cycle after it is accepted, carrying the line
// drives, busy, done, status and the received byte. A request can be taken in
// every cycle: the handshake state machine advances once per tick in a single
// pass of logic and the result sits in an output register, so in_stall is
// raised only while that register holds a result that out_stall is holding
// back. Timeouts are counted in ticks and set through the configuration port
// (index 0 handshake wait, index 1 wait for the peer to start a bit); both
// reset to 1000000.
// ----------------------------------------------------------------------------
module two_wire_handshake_byte_link
  import twhbl_pkg::*;
#(
  parameter int unsigned BITS_PER_CHAR = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  // input request channel
  input  logic               in_valid,
  output logic               in_stall,
  input  in_t                in_data,
  // result channel
  output logic               out_valid,
  input  logic               out_stall,
  output out_t               out_data,
  // configuration write port
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [TIMER_W-1:0] cfg_data
);

  cfg_t        cfg;
  link_state_t st_r, st_nxt;
  out_t        res;
  out_t        out_data_r;
  logic        out_valid_r, out_valid_nxt;
  logic        in_take;

  twhbl_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  twhbl_step #(
    .BITS_PER_CHAR (BITS_PER_CHAR)
  ) u_step (
    .st_cur (st_r),
    .item   (in_data),
    .cfg    (cfg),
    .st_nxt (st_nxt),
    .res    (res)
  );

  // output register full and held back: nowhere to put the next result
  assign in_stall = out_valid_r && out_stall;
  assign in_take  = in_valid && !in_stall;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (in_take) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  // link state only moves on an accepted tick
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.phase       <= PH_IDLE;
      st_r.receiving   <= 1'b0;
      st_r.bits_done   <= 4'd0;
      st_r.shift_reg   <= 8'd0;
      st_r.wait_timer  <= '0;
      st_r.current_bit <= 1'b0;
      st_r.drive_lines <= DRV_NONE;
      out_valid_r      <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (in_take) begin
        st_r <= st_nxt;
      end
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk) begin
    if (in_take) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

FILE: hdl/twhbl_checker.sv
// ----------------------------------------------------------------------------
// twhbl_checker
// Port-level checks on the byte link result stream, bound to the top level.
// ----------------------------------------------------------------------------
module twhbl_checker
  import twhbl_pkg::*;
(
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_stall,
  input out_t               out_data
);

  // a held result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // a finished transfer is no longer busy
  a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.done_res |-> !out_data.busy_res)
    else $error("done while still busy");

  // status only reported with done
  a_status_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.done_res |-> out_data.status == ST_OK)
    else $error("status without done");

  // both lines released at the end of a transfer
  a_done_released: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.done_res |-> !out_data.tip_pull_low && !out_data.ring_pull_low)
    else $error("line still driven at end of transfer");

  // a received byte only appears on a successful completion
  a_rx_on_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.rx_byte != 8'd0 |-> out_data.done_res && out_data.status == ST_OK)
    else $error("received byte outside a good completion");

endmodule

bind two_wire_handshake_byte_link twhbl_checker u_twhbl_checker (.*);
